// File: hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Request/result transaction types, header word layout, datapath command set.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  // Heap geometry
  localparam int HEAP_WORDS = 4096;
  localparam int ADDR_W     = 12;            // payload/header address bits
  localparam int PTR_W      = ADDR_W + 1;    // links, sizes and region bounds
  localparam int SLACK_W    = 4;

  localparam logic [PTR_W-1:0]   NIL_LINK    = PTR_W'(HEAP_WORDS);
  localparam logic [PTR_W-1:0]   HEAP_TOP    = PTR_W'(HEAP_WORDS);
  localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(2);

  // Request codes
  typedef enum logic [1:0] {
    REQ_PERM    = 2'd0,
    REQ_TEMP    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_QUERY   = 2'd3
  } req_kind_t;

  // Input transaction
  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] word_count;
    logic [ADDR_W-1:0] address;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] block_words;
    logic              failed;
    logic [PTR_W-1:0]  used_words;
  } rsp_t;

  // One header word: block size and free-list link
  typedef struct packed {
    logic [PTR_W-1:0] size;
    logic [PTR_W-1:0] next;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  // Datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAIL,
    OP_PERM,
    OP_BUMP,
    OP_RD_CUR,
    OP_RD_F,
    OP_RD_LINK,
    OP_STEP,
    OP_TAKE,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_QUERY,
    OP_REL_START,
    OP_REL_EMPTY,
    OP_REL_FRONT,
    OP_REL_PREV,
    OP_REL_LAST,
    OP_REL_NEXT
  } dp_op_t;

  // Datapath status to the controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       zero_req;
    logic       head_nil;
    logic       room_perm;
    logic       room_temp;
    logic       bad_addr;
    logic       steps_max;
    logic       fits;
    logic       absorb;
    logic       next_nil;
    logic       f_below_head;
    logic       walk_more;
    logic       adj_next;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit free-list heap allocator
// Permanent and temporary allocation, release with coalescing, size query.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, on rsp for the single cycle in which done is high, and it cannot be
// held off. A permanent allocate, a zero-word request, and a release or size
// query at address zero finish without a header access. A temporary allocate
// reads the free list one entry at a time, and then takes a block whole, splits
// it, or runs off the end of the list and bumps. A release inserts the block
// into an empty list, in front of the head, or after a walk, where a merge with
// the upper neighbor takes an extra read. The walk is set by the
// one-read-per-entry header memory, so latency grows with free-list
// fragmentation. busy stays high through the done cycle and falls at the edge
// that ends it, so the next request is accepted no earlier than the cycle after
// the result. The slack register may be written only between transactions.
`default_nettype none

module first_fit_heap_allocator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire ffha_pkg::req_t               req,
  output logic                              busy,
  output logic                              done,
  output ffha_pkg::rsp_t                    rsp,
  input  wire logic                         cfg_we,
  input  wire logic [ffha_pkg::SLACK_W-1:0] cfg_wdata
);

  ffha_pkg::dp_op_t   op;
  ffha_pkg::dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  ffha_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // A result only appears inside an accepted transaction
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a transaction");

  // Accepting a request makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not start");

  // Exactly one result per transaction: busy falls right after done
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("transaction did not end after its result");

  // Datapath commands other than the request load only run inside a transaction
  a_op_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && op != ffha_pkg::OP_NONE) |-> (op == ffha_pkg::OP_LOAD))
    else $error("datapath command issued while idle");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ffha_datapath.sv
// ----------------------------------------------------------------------------
// ffha_datapath: allocator registers, header memory and list arithmetic
// Executes one controller command per cycle and reports status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ffha_pkg::dp_op_t               op,
  input  wire ffha_pkg::req_t                 req,
  input  wire logic                           cfg_we,
  input  wire logic [ffha_pkg::SLACK_W-1:0]   cfg_wdata,
  output ffha_pkg::dp_stat_t                  stat,
  output ffha_pkg::rsp_t                      rsp
);

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int PW = ffha_pkg::PTR_W;

  // Persistent allocator state
  logic [PW-1:0]                free_head;
  logic [PW-1:0]                region_low;
  logic [PW-1:0]                region_high;
  logic [PW-1:0]                free_total;
  logic [ffha_pkg::SLACK_W-1:0] slack;

  // Per-transaction working registers
  ffha_pkg::req_t req_q;
  logic [PW-1:0]  cur;
  logic [PW-1:0]  prev;
  logic [PW-1:0]  prev_size;
  logic [PW-1:0]  steps;
  logic [AW-1:0]  fbase;
  logic [PW-1:0]  fsz;
  logic [PW-1:0]  link;
  logic [AW-1:0]  res_addr;
  logic [AW-1:0]  res_words;
  logic           res_fail;

  // Header memory
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  ffha_pkg::hdr_t               ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [ffha_pkg::HDR_W-1:0]   ram_rdata;
  ffha_pkg::hdr_t               rd;

  ffha_ram #(
    .WIDTH (ffha_pkg::HDR_W),
    .DEPTH (ffha_pkg::HEAP_WORDS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = ffha_pkg::hdr_t'(ram_rdata);

  // Common arithmetic
  logic [PW-1:0] need;
  logic [AW-1:0] f;
  logic [PW-1:0] gap;
  logic [PW-1:0] rem;
  logic [AW-1:0] split_addr;
  logic [PW:0]   cur_end;
  logic [PW:0]   f_end;
  logic [PW:0]   fbase_end;
  logic [PW-1:0] rd_size_m1;
  logic [PW-1:0] perm_top;
  logic [PW-1:0] merged_sz;
  logic          front_adj;
  logic          prev_adj;

  assign need       = {1'b0, req_q.word_count} + PW'(1);
  assign f          = req_q.address - AW'(1);
  assign gap        = region_high - region_low;
  assign rem        = rd.size - need;
  assign split_addr = cur[AW-1:0] + rem[AW-1:0];
  assign cur_end    = {1'b0, cur} + {1'b0, rd.size};
  assign f_end      = {2'b00, f} + {1'b0, fsz};
  assign fbase_end  = {2'b00, fbase} + {1'b0, fsz};
  assign rd_size_m1 = rd.size - PW'(1);
  assign perm_top   = region_high - {1'b0, req_q.word_count};
  assign merged_sz  = fsz + rd.size;
  assign front_adj  = (f_end == {1'b0, cur});
  assign prev_adj   = (cur_end == {2'b00, f});

  // Status to the controller
  always_comb begin
    stat.req_type     = req_q.req_type;
    stat.zero_req     = (req_q.word_count == '0);
    stat.head_nil     = (free_head == ffha_pkg::NIL_LINK);
    stat.room_perm    = (gap >= {1'b0, req_q.word_count});
    stat.room_temp    = (gap >= need);
    stat.bad_addr     = (req_q.address == '0);
    stat.steps_max    = (steps == ffha_pkg::HEAP_TOP);
    stat.fits         = (rd.size >= need);
    stat.absorb       = (rem <= {{(PW-ffha_pkg::SLACK_W){1'b0}}, slack});
    stat.next_nil     = (rd.next == ffha_pkg::NIL_LINK);
    stat.f_below_head = ({1'b0, f} < free_head);
    stat.walk_more    = (rd.next != ffha_pkg::NIL_LINK) && (rd.next < {1'b0, f}) &&
                        (steps < ffha_pkg::HEAP_TOP);
    stat.adj_next     = (link != ffha_pkg::NIL_LINK) && (fbase_end == {1'b0, link});
  end

  // Header memory access per command
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (op)
      ffha_pkg::OP_RD_CUR: begin
        ram_re    = 1'b1;
        ram_raddr = cur[AW-1:0];
      end
      ffha_pkg::OP_RD_F: begin
        ram_re    = 1'b1;
        ram_raddr = f;
      end
      ffha_pkg::OP_RD_LINK: begin
        ram_re    = 1'b1;
        ram_raddr = link[AW-1:0];
      end
      ffha_pkg::OP_TAKE: begin
        // unlink from predecessor; the head register covers the first entry
        ram_we    = (prev != ffha_pkg::NIL_LINK);
        ram_waddr = prev[AW-1:0];
        ram_wdata = '{size: prev_size, next: rd.next};
      end
      ffha_pkg::OP_SPLIT1: begin
        ram_we    = 1'b1;
        ram_waddr = cur[AW-1:0];
        ram_wdata = '{size: rem, next: rd.next};
        // fetch the carved header so its old link is kept by the size write
        ram_re    = 1'b1;
        ram_raddr = split_addr;
      end
      ffha_pkg::OP_SPLIT2: begin
        ram_we    = 1'b1;
        ram_waddr = fbase;
        ram_wdata = '{size: need, next: rd.next};
      end
      ffha_pkg::OP_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = region_low[AW-1:0];
        ram_wdata = '{size: need, next: '0};
      end
      ffha_pkg::OP_REL_EMPTY: begin
        ram_we    = 1'b1;
        ram_waddr = f;
        ram_wdata = '{size: fsz, next: ffha_pkg::NIL_LINK};
      end
      ffha_pkg::OP_REL_FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = f;
        ram_wdata = front_adj ? ffha_pkg::hdr_t'{size: merged_sz, next: rd.next}
                              : ffha_pkg::hdr_t'{size: fsz, next: cur};
      end
      ffha_pkg::OP_REL_PREV: begin
        ram_we    = 1'b1;
        ram_waddr = cur[AW-1:0];
        ram_wdata = prev_adj ? ffha_pkg::hdr_t'{size: merged_sz, next: rd.next}
                             : ffha_pkg::hdr_t'{size: rd.size, next: {1'b0, f}};
      end
      ffha_pkg::OP_REL_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = fbase;
        ram_wdata = '{size: fsz, next: link};
      end
      ffha_pkg::OP_REL_NEXT: begin
        ram_we    = 1'b1;
        ram_waddr = fbase;
        ram_wdata = '{size: merged_sz, next: rd.next};
      end
      default: begin
      end
    endcase
  end

  // Allocator state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= ffha_pkg::NIL_LINK;
      region_low  <= '0;
      region_high <= ffha_pkg::HEAP_TOP;
      free_total  <= '0;
      slack       <= ffha_pkg::SLACK_RESET;
    end else begin
      if (cfg_we) begin
        slack <= cfg_wdata;
      end
      case (op)
        ffha_pkg::OP_PERM:      region_high <= perm_top;
        ffha_pkg::OP_BUMP:      region_low  <= region_low + need;
        ffha_pkg::OP_TAKE: begin
          if (prev == ffha_pkg::NIL_LINK) begin
            free_head <= rd.next;
          end
          free_total <= free_total - rd.size;
        end
        ffha_pkg::OP_SPLIT1:    free_total <= free_total - need;
        ffha_pkg::OP_REL_START: free_total <= free_total + rd.size;
        ffha_pkg::OP_REL_EMPTY: free_head  <= {1'b0, f};
        ffha_pkg::OP_REL_FRONT: free_head  <= {1'b0, f};
        default: begin
        end
      endcase
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    case (op)
      ffha_pkg::OP_LOAD: begin
        req_q     <= req;
        cur       <= free_head;
        prev      <= ffha_pkg::NIL_LINK;
        steps     <= '0;
        res_addr  <= '0;
        res_words <= '0;
        res_fail  <= 1'b0;
      end
      ffha_pkg::OP_FAIL: res_fail <= 1'b1;
      ffha_pkg::OP_PERM: begin
        res_addr  <= perm_top[AW-1:0];
        res_words <= req_q.word_count;
      end
      ffha_pkg::OP_BUMP: begin
        res_addr  <= region_low[AW-1:0] + AW'(1);
        res_words <= req_q.word_count;
      end
      ffha_pkg::OP_STEP: begin
        prev      <= cur;
        prev_size <= rd.size;
        cur       <= rd.next;
        steps     <= steps + PW'(1);
      end
      ffha_pkg::OP_TAKE: begin
        res_addr  <= cur[AW-1:0] + AW'(1);
        res_words <= rd_size_m1[AW-1:0];
      end
      ffha_pkg::OP_SPLIT1: begin
        res_addr  <= split_addr + AW'(1);
        res_words <= req_q.word_count;
        fbase     <= split_addr;
      end
      ffha_pkg::OP_QUERY: begin
        res_words <= (rd.size == '0) ? '0 : rd_size_m1[AW-1:0];
      end
      ffha_pkg::OP_REL_START: begin
        fsz   <= rd.size;
        fbase <= f;
      end
      ffha_pkg::OP_REL_PREV: begin
        link <= rd.next;
        if (prev_adj) begin
          fbase <= cur[AW-1:0];
          fsz   <= merged_sz;
        end
      end
      default: begin
      end
    endcase
  end

  // Result transaction fields
  always_comb begin
    rsp.block_address = res_addr;
    rsp.block_words   = res_words;
    rsp.failed        = res_fail;
    rsp.used_words    = ffha_pkg::HEAP_TOP - free_total - gap;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl: allocator sequencer
// Steps each request through reads, list walks and header writes.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_op_t        op,
  output logic                    busy,
  output logic                    done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_T_WAIT,
    S_T_RD,
    S_SPLIT2,
    S_BUMP,
    S_Q_WAIT,
    S_R_F,
    S_R_DEC,
    S_R_FRONT,
    S_R_WALK,
    S_R_RD,
    S_R_NEXT,
    S_R_MERGE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Command and next state
  always_comb begin
    op         = ffha_pkg::OP_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          op         = ffha_pkg::OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req_type)
          ffha_pkg::REQ_PERM: begin
            op         = (stat.zero_req || !stat.room_perm) ? ffha_pkg::OP_FAIL
                                                            : ffha_pkg::OP_PERM;
            state_next = S_DONE;
          end
          ffha_pkg::REQ_TEMP: begin
            if (stat.zero_req) begin
              op         = ffha_pkg::OP_FAIL;
              state_next = S_DONE;
            end else if (stat.head_nil) begin
              state_next = S_BUMP;
            end else begin
              op         = ffha_pkg::OP_RD_CUR;
              state_next = S_T_WAIT;
            end
          end
          ffha_pkg::REQ_RELEASE: begin
            if (stat.bad_addr) begin
              state_next = S_DONE;
            end else begin
              op         = ffha_pkg::OP_RD_F;
              state_next = S_R_F;
            end
          end
          default: begin
            if (stat.bad_addr) begin
              state_next = S_DONE;
            end else begin
              op         = ffha_pkg::OP_RD_F;
              state_next = S_Q_WAIT;
            end
          end
        endcase
      end
      // first-fit search, one list entry per read
      S_T_WAIT: begin
        if (stat.steps_max) begin
          state_next = S_BUMP;
        end else if (stat.fits) begin
          if (stat.absorb) begin
            op         = ffha_pkg::OP_TAKE;
            state_next = S_DONE;
          end else begin
            op         = ffha_pkg::OP_SPLIT1;
            state_next = S_SPLIT2;
          end
        end else begin
          op         = ffha_pkg::OP_STEP;
          state_next = stat.next_nil ? S_BUMP : S_T_RD;
        end
      end
      S_T_RD: begin
        op         = ffha_pkg::OP_RD_CUR;
        state_next = S_T_WAIT;
      end
      S_SPLIT2: begin
        op         = ffha_pkg::OP_SPLIT2;
        state_next = S_DONE;
      end
      S_BUMP: begin
        op         = stat.room_temp ? ffha_pkg::OP_BUMP : ffha_pkg::OP_FAIL;
        state_next = S_DONE;
      end
      S_Q_WAIT: begin
        op         = ffha_pkg::OP_QUERY;
        state_next = S_DONE;
      end
      // release: insert in address order, merge both sides
      S_R_F: begin
        op         = ffha_pkg::OP_REL_START;
        state_next = S_R_DEC;
      end
      S_R_DEC: begin
        if (stat.head_nil) begin
          op         = ffha_pkg::OP_REL_EMPTY;
          state_next = S_DONE;
        end else begin
          op         = ffha_pkg::OP_RD_CUR;
          state_next = stat.f_below_head ? S_R_FRONT : S_R_WALK;
        end
      end
      S_R_FRONT: begin
        op         = ffha_pkg::OP_REL_FRONT;
        state_next = S_DONE;
      end
      S_R_WALK: begin
        if (stat.walk_more) begin
          op         = ffha_pkg::OP_STEP;
          state_next = S_R_RD;
        end else begin
          op         = ffha_pkg::OP_REL_PREV;
          state_next = S_R_NEXT;
        end
      end
      S_R_RD: begin
        op         = ffha_pkg::OP_RD_CUR;
        state_next = S_R_WALK;
      end
      S_R_NEXT: begin
        if (stat.adj_next) begin
          op         = ffha_pkg::OP_RD_LINK;
          state_next = S_R_MERGE;
        end else begin
          op         = ffha_pkg::OP_REL_LAST;
          state_next = S_DONE;
        end
      end
      S_R_MERGE: begin
        op         = ffha_pkg::OP_REL_NEXT;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state_next == S_DONE);
      if (state == S_IDLE && start && !busy) begin
        busy <= 1'b1;
      end else if (state == S_DONE) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
